/* rtl/core/srbp_pkg.sv */
// shared types and constants for the sample record binary parser
`timescale 1ns / 1ps

package srbp_pkg;

  localparam logic [9:0] MAX_CHANNELS = 10'd1023;

  localparam logic [0:0] REG_ANALOG_COUNT  = 1'b0;
  localparam logic [0:0] REG_DIGITAL_COUNT = 1'b1;

  localparam logic [15:0] MISSING_MARK = 16'h8000;

  typedef enum logic [2:0] {
    KIND_SAMPLE_NUM = 3'd0,
    KIND_TIMESTAMP  = 3'd1,
    KIND_ANALOG     = 3'd2,
    KIND_DIGITAL    = 3'd3,
    KIND_TRUNCATED  = 3'd4
  } kind_t;

  typedef enum logic [1:0] {
    PH_SAMPLE  = 2'd0,
    PH_STAMP   = 2'd1,
    PH_ANALOG  = 2'd2,
    PH_DIGITAL = 2'd3
  } phase_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_data;
  } byte_item_t;

  typedef struct packed {
    logic [2:0]         field_kind;
    logic [9:0]         channel_index;
    logic [31:0]        word_value;
    logic signed [15:0] analog_value;
    logic               sample_valid;
    logic               record_done;
    logic               run_last;
  } result_item_t;

  typedef struct packed {
    logic [9:0] analog_count;
    logic [9:0] digital_count;
  } cfg_t;

  // one group of results caused by a single byte
  typedef struct packed {
    kind_t       kind;
    logic [9:0]  ch_base;
    logic [31:0] value;
    logic [15:0] analog;
    logic        valid;
    logic        rec_done;
    logic [3:0]  last_bit;
  } group_t;

  function automatic logic [9:0] clamp_count(input logic [9:0] c);
    return (c > MAX_CHANNELS) ? MAX_CHANNELS : c;
  endfunction

endpackage

/* rtl/core/srbp_cfg_regs.sv */
// apb register file holding the channel counts
`timescale 1ns / 1ps

module srbp_cfg_regs
  import srbp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg
);

  logic [9:0] analog_count;
  logic [9:0] digital_count;
  logic       wr_en;
  logic [0:0] reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = paddr[2:2];
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      analog_count  <= '0;
      digital_count <= '0;
    end else if (wr_en) begin
      case (reg_sel)
        REG_ANALOG_COUNT:  analog_count  <= pwdata[9:0];
        REG_DIGITAL_COUNT: digital_count <= pwdata[9:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_ANALOG_COUNT:  prdata = {22'd0, analog_count};
      REG_DIGITAL_COUNT: prdata = {22'd0, digital_count};
      default:           prdata = '0;
    endcase
  end

  assign cfg.analog_count  = analog_count;
  assign cfg.digital_count = digital_count;

endmodule

/* rtl/core/srbp_parse.sv */
// record parser state and per-byte field decode
`timescale 1ns / 1ps

module srbp_parse
  import srbp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  byte_item_t item,
  input  cfg_t       cfg,
  output logic       grp_load,
  output group_t     grp
);

  phase_t      record_phase, record_phase_next;
  logic [1:0]  byte_in_field, byte_in_field_next;
  logic [23:0] partial_bytes, partial_bytes_next;
  logic [9:0]  analog_counter, analog_counter_next;
  logic [6:0]  digital_word_counter, digital_word_counter_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      record_phase         <= PH_SAMPLE;
      byte_in_field        <= '0;
      partial_bytes        <= '0;
      analog_counter       <= '0;
      digital_word_counter <= '0;
    end else if (accept) begin
      record_phase         <= record_phase_next;
      byte_in_field        <= byte_in_field_next;
      partial_bytes        <= partial_bytes_next;
      analog_counter       <= analog_counter_next;
      digital_word_counter <= digital_word_counter_next;
    end
  end

  always_comb begin
    logic        complete;
    logic        rec_end;
    logic        produce;
    logic [31:0] v;
    logic [9:0]  ac;
    logic [9:0]  dc;
    logic [6:0]  words;
    logic [10:0] base;
    logic [10:0] rem;

    record_phase_next         = record_phase;
    byte_in_field_next        = byte_in_field;
    partial_bytes_next        = partial_bytes;
    analog_counter_next       = analog_counter;
    digital_word_counter_next = digital_word_counter;
    rec_end = 1'b0;
    produce = 1'b0;

    ac    = clamp_count(cfg.analog_count);
    dc    = clamp_count(cfg.digital_count);
    words = 7'((11'(dc) + 11'd15) >> 4);
    base  = {digital_word_counter, 4'd0};
    rem   = (11'(dc) > base) ? (11'(dc) - base) : 11'd0;
    v     = {8'd0, partial_bytes} | ({24'd0, item.data_byte} << {byte_in_field, 3'b000});

    grp.kind     = KIND_SAMPLE_NUM;
    grp.ch_base  = '0;
    grp.value    = v;
    grp.analog   = '0;
    grp.valid    = 1'b1;
    grp.rec_done = 1'b0;
    grp.last_bit = '0;

    if (record_phase == PH_SAMPLE || record_phase == PH_STAMP) begin
      complete = (byte_in_field == 2'd3);
    end else begin
      complete = (byte_in_field != 2'd0);
    end

    if (!complete) begin
      partial_bytes_next = v[23:0];
      byte_in_field_next = byte_in_field + 2'd1;
    end else begin
      produce            = 1'b1;
      byte_in_field_next = '0;
      partial_bytes_next = '0;
      case (record_phase)
        PH_SAMPLE: begin
          grp.kind          = KIND_SAMPLE_NUM;
          record_phase_next = PH_STAMP;
        end
        PH_STAMP: begin
          grp.kind                  = KIND_TIMESTAMP;
          analog_counter_next       = '0;
          digital_word_counter_next = '0;
          if (ac != 10'd0) begin
            record_phase_next = PH_ANALOG;
          end else if (words != 7'd0) begin
            record_phase_next = PH_DIGITAL;
          end else begin
            rec_end = 1'b1;
          end
        end
        PH_ANALOG: begin
          grp.kind    = KIND_ANALOG;
          grp.ch_base = analog_counter;
          grp.value   = '0;
          grp.analog  = v[15:0];
          grp.valid   = (v[15:0] != MISSING_MARK);
          if (11'(analog_counter) + 11'd1 >= 11'(ac)) begin
            analog_counter_next = '0;
            if (words != 7'd0) begin
              record_phase_next = PH_DIGITAL;
            end else begin
              rec_end = 1'b1;
            end
          end else begin
            analog_counter_next = analog_counter + 10'd1;
          end
        end
        default: begin
          grp.kind    = KIND_DIGITAL;
          grp.ch_base = base[9:0];
          grp.value   = {16'd0, v[15:0]};
          // count of bits this word carries, minus one
          if (rem >= 11'd16) begin
            grp.last_bit = 4'd15;
          end else if (rem == 11'd0) begin
            grp.last_bit = 4'd0;
          end else begin
            grp.last_bit = rem[3:0] - 4'd1;
          end
          if (8'(digital_word_counter) + 8'd1 >= 8'(words)) begin
            digital_word_counter_next = '0;
            rec_end = 1'b1;
          end else begin
            digital_word_counter_next = digital_word_counter + 7'd1;
          end
        end
      endcase
    end

    grp.rec_done = rec_end;

    // stream ends inside a record: one truncation result replaces the rest
    if (item.end_of_data && !rec_end) begin
      produce      = 1'b1;
      grp.kind     = KIND_TRUNCATED;
      grp.ch_base  = '0;
      grp.value    = '0;
      grp.analog   = '0;
      grp.valid    = 1'b0;
      grp.rec_done = 1'b1;
      grp.last_bit = '0;
    end

    if (rec_end || item.end_of_data) begin
      record_phase_next         = PH_SAMPLE;
      byte_in_field_next        = '0;
      partial_bytes_next        = '0;
      analog_counter_next       = '0;
      digital_word_counter_next = '0;
    end

    grp_load = accept && produce;
  end

endmodule

/* rtl/core/srbp_expand.sv */
// result register that expands a group into one result per cycle while result_ready is high
`timescale 1ns / 1ps

module srbp_expand
  import srbp_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         grp_load,
  input  group_t       grp,
  output logic         slot_free,
  output logic         result_valid,
  input  logic         result_ready,
  output result_item_t result_item
);

  logic       held;
  group_t     cur;
  logic [3:0] bit_pos;
  logic       last_one;
  logic       take;

  assign last_one  = (bit_pos == cur.last_bit);
  assign take      = held && result_ready;
  assign slot_free = !held || (take && last_one);

  always_ff @(posedge clk) begin
    if (rst) begin
      held    <= 1'b0;
      bit_pos <= '0;
    end else if (grp_load) begin
      held    <= 1'b1;
      bit_pos <= '0;
    end else if (take) begin
      if (last_one) begin
        held <= 1'b0;
      end else begin
        bit_pos <= bit_pos + 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (grp_load) begin
      cur <= grp;
    end
  end

  assign result_valid = held;

  always_comb begin
    result_item.field_kind    = cur.kind;
    result_item.analog_value  = cur.analog;
    result_item.sample_valid  = cur.valid;
    result_item.record_done   = cur.rec_done && last_one;
    result_item.run_last      = last_one;
    if (cur.kind == KIND_DIGITAL) begin
      result_item.channel_index = cur.ch_base + 10'(bit_pos);
      result_item.word_value    = {31'd0, cur.value[{1'b0, bit_pos}]};
    end else begin
      result_item.channel_index = cur.ch_base;
      result_item.word_value    = cur.value;
    end
  end

endmodule

/* rtl/core/sample_record_binary_parser.sv */
// top level of the sample record binary parser
`timescale 1ns / 1ps

// takes one byte of a stream of fixed-layout sample records per cycle and
// assembles little-endian fields: a 32-bit sample number, a 32-bit timestamp,
// analog_count signed 16-bit analog words (0x8000 flags a missing sample) and
// ceil(digital_count/16) digital words that give one result per channel bit.
// a byte that only adds to a partial field gives no result. a byte that
// finishes a field gives a group of results that the result register hands
// out one per cycle: one result for most fields, up to 16 for a digital word.
// the next byte is taken in the cycle that the last result of the previous
// group leaves, so the input runs at one byte per cycle except behind digital
// words and output stalls. a byte flagged with end_of_data that does not close
// the record gives a single truncation result and the parser returns to the
// record start. channel counts are set over apb at byte addresses 0 and 4; the
// user must set them only while the block is idle; the block does not check.

module sample_record_binary_parser
  import srbp_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  // byte channel
  input  logic         byte_valid,
  output logic         byte_ready,
  input  byte_item_t   byte_item,
  // result channel
  output logic         result_valid,
  input  logic         result_ready,
  output result_item_t result_item,
  // configuration port
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  cfg_t   cfg;
  group_t grp;
  logic   grp_load;
  logic   slot_free;
  logic   accept;

  // a byte goes in whenever the result register is empty or emptying
  assign byte_ready = slot_free;
  assign accept     = byte_valid && byte_ready;

  srbp_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // field assembly and record sequencing
  srbp_parse u_parse (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .item     (byte_item),
    .cfg      (cfg),
    .grp_load (grp_load),
    .grp      (grp)
  );

  // result register, one result per cycle out of each group while result_ready is high
  srbp_expand u_expand (
    .clk          (clk),
    .rst          (rst),
    .grp_load     (grp_load),
    .grp          (grp),
    .slot_free    (slot_free),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result_item  (result_item)
  );

endmodule

/* tb/sv/srbp_result_checker.sv */
// result checker for the sample record binary parser: field predictor and comparison
`timescale 1ns / 1ps

module srbp_result_checker
  import srbp_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         byte_valid,
  input  logic         byte_ready,
  input  byte_item_t   byte_item,
  input  logic         result_valid,
  input  logic         result_ready,
  input  result_item_t result_item,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic         pready,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output int           fail_count,
  output int           pending
);

  logic [9:0]   ana_count;
  logic [9:0]   dig_count;
  phase_t       phase;
  int           byte_pos;
  logic [23:0]  partial;
  int           ana_idx;
  int           word_idx;
  result_item_t parsed_fields_q[$];

  function automatic result_item_t field_of(kind_t k, int ch, logic [31:0] w,
                                            logic [15:0] a, logic ok);
    result_item_t r;
    r.field_kind    = k;
    r.channel_index = 10'(ch);
    r.word_value    = w;
    r.analog_value  = a;
    r.sample_valid  = ok;
    r.record_done   = 1'b0;
    r.run_last      = 1'b0;
    return r;
  endfunction

  task automatic restart_record();
    phase    = PH_SAMPLE;
    byte_pos = 0;
    partial  = '0;
    ana_idx  = 0;
    word_idx = 0;
  endtask

  // works out the fields that one byte finishes and queues them
  task automatic parse_byte(input byte_item_t it);
    result_item_t grp[$];
    logic [31:0]  v;
    int           need;
    int           words;
    int           base;
    int           rem;
    int           nbits;
    logic         rec_end;
    need    = (phase == PH_SAMPLE || phase == PH_STAMP) ? 4 : 2;
    rec_end = 1'b0;
    if (byte_pos + 1 < need) begin
      partial  = partial | (24'(it.data_byte) << (8 * byte_pos));
      byte_pos = byte_pos + 1;
    end else begin
      v        = {8'd0, partial} | (32'(it.data_byte) << (8 * byte_pos));
      words    = (int'(dig_count) + 15) / 16;
      byte_pos = 0;
      partial  = '0;
      case (phase)
        PH_SAMPLE: begin
          grp.push_back(field_of(KIND_SAMPLE_NUM, 0, v, 16'd0, 1'b1));
          phase = PH_STAMP;
        end
        PH_STAMP: begin
          grp.push_back(field_of(KIND_TIMESTAMP, 0, v, 16'd0, 1'b1));
          ana_idx  = 0;
          word_idx = 0;
          if (ana_count != 0) phase = PH_ANALOG;
          else if (words > 0) phase = PH_DIGITAL;
          else rec_end = 1'b1;
        end
        PH_ANALOG: begin
          grp.push_back(field_of(KIND_ANALOG, ana_idx, 32'd0, v[15:0],
                                 v[15:0] != MISSING_MARK));
          // count compared after each word, so a shrunk count ends the section
          if (ana_idx + 1 >= int'(ana_count)) begin
            ana_idx = 0;
            if (words > 0) phase = PH_DIGITAL;
            else rec_end = 1'b1;
          end else begin
            ana_idx = ana_idx + 1;
          end
        end
        default: begin
          base  = 16 * word_idx;
          rem   = (int'(dig_count) > base) ? int'(dig_count) - base : 0;
          nbits = (rem >= 16) ? 16 : ((rem == 0) ? 1 : rem);
          for (int p = 0; p < nbits; p++)
            grp.push_back(field_of(KIND_DIGITAL, base + p, {31'd0, v[p]}, 16'd0, 1'b1));
          if (word_idx + 1 >= words) begin
            word_idx = 0;
            rec_end  = 1'b1;
          end else begin
            word_idx = (word_idx + 1) & 'h7F;
          end
        end
      endcase
      if (rec_end) begin
        restart_record();
        grp[grp.size() - 1].record_done = 1'b1;
      end
    end
    // end of data inside a record replaces everything with one truncation
    if (it.end_of_data && !rec_end) begin
      grp.delete();
      grp.push_back(field_of(KIND_TRUNCATED, 0, 32'd0, 16'd0, 1'b0));
      grp[0].record_done = 1'b1;
      restart_record();
    end
    if (grp.size() > 0) grp[grp.size() - 1].run_last = 1'b1;
    foreach (grp[i]) parsed_fields_q.push_back(grp[i]);
  endtask

  task automatic check_field(input string nm, input logic [31:0] e, input logic [31:0] a);
    if (e !== a) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, nm, e, a);
      fail_count = fail_count + 1;
    end
  endtask

  always @(posedge clk) begin : watch
    result_item_t exp_r;
    if (rst) begin
      ana_count  = '0;
      dig_count  = '0;
      restart_record();
      parsed_fields_q.delete();
      fail_count = 0;
      pending    = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == REG_DIGITAL_COUNT) dig_count = pwdata[9:0];
        else ana_count = pwdata[9:0];
      end
      if (result_valid && result_ready) begin
        if (parsed_fields_q.size() == 0) begin
          $display("%0t: unexpected item, expected none, got %p", $time, result_item);
          fail_count = fail_count + 1;
        end else begin
          exp_r = parsed_fields_q.pop_front();
          check_field("field_kind", 32'(exp_r.field_kind), 32'(result_item.field_kind));
          check_field("channel_index", 32'(exp_r.channel_index),
                      32'(result_item.channel_index));
          check_field("word_value", exp_r.word_value, result_item.word_value);
          check_field("analog_value", {16'd0, exp_r.analog_value},
                      {16'd0, result_item.analog_value});
          check_field("sample_valid", 32'(exp_r.sample_valid), 32'(result_item.sample_valid));
          check_field("record_done", 32'(exp_r.record_done), 32'(result_item.record_done));
          check_field("run_last", 32'(exp_r.run_last), 32'(result_item.run_last));
        end
      end
      if (byte_valid && byte_ready) parse_byte(byte_item);
      pending = parsed_fields_q.size();
    end
  end

endmodule

/* tb/sv/tb_sample_record_binary_parser.sv */
// testbench top for the sample record binary parser: stimulus, handshakes and verdict
`timescale 1ns / 1ps

module tb_sample_record_binary_parser;
  import srbp_pkg::*;

  localparam int HALF_PERIOD  = 10;
  localparam int RESET_CYCLES = 10;
  // settling wait for a byte that adds to a partial field and gives no result
  localparam int DRAIN_GAP    = 4;
  // cycles with no item moving on either channel before giving up
  localparam int STALL_LIMIT  = 4000;
  // long receiver hold-off, enough to back the block up into its input
  localparam int LONG_HOLD    = 300;

  typedef logic [7:0] octet_q_t[$];

  logic         clk          = 1'b0;
  logic         rst          = 1'b1;
  logic         byte_valid   = 1'b0;
  logic         byte_ready;
  byte_item_t   byte_item    = '0;
  logic         result_valid;
  logic         result_ready = 1'b0;
  result_item_t result_item;
  logic         psel         = 1'b0;
  logic         penable      = 1'b0;
  logic         pwrite       = 1'b0;
  logic [2:0]   paddr        = '0;
  logic [31:0]  pwdata       = '0;
  logic [31:0]  prdata;
  logic         pready;

  int           fail_count;
  int           pending;

  // idle knobs: sender gap and receiver stall, in percent
  int           gap_pct      = 0;
  int           stall_pct    = 0;
  logic         hold_req     = 1'b0;
  logic         hold_done    = 1'b0;
  int           hold_left    = 0;
  int           quiet_cycles = 0;

  // stimulus copy of the channel counts, used only to size records
  logic [9:0]   cur_ac       = '0;
  logic [9:0]   cur_dc       = '0;

  always #HALF_PERIOD clk = ~clk;

  sample_record_binary_parser u_top (
    .clk          (clk),
    .rst          (rst),
    .byte_valid   (byte_valid),
    .byte_ready   (byte_ready),
    .byte_item    (byte_item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result_item  (result_item),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  srbp_result_checker u_chk (
    .clk          (clk),
    .rst          (rst),
    .byte_valid   (byte_valid),
    .byte_ready   (byte_ready),
    .byte_item    (byte_item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result_item  (result_item),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .pready       (pready),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .fail_count   (fail_count),
    .pending      (pending)
  );

  // result side: random stalls, plus one long hold-off counted here
  always @(negedge clk) begin
    if (rst) begin
      result_ready <= 1'b0;
    end else if (hold_req && !hold_done) begin
      hold_done    <= 1'b1;
      hold_left    <= LONG_HOLD;
      result_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left    <= hold_left - 1;
      result_ready <= 1'b0;
    end else begin
      result_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // watchdog: nothing moving for too long means the block is stuck
  always @(posedge clk) begin
    if (rst) begin
      quiet_cycles <= 0;
    end else if ((byte_valid && byte_ready) || (result_valid && result_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // offer one byte item, with an optional random gap first, and hold it until taken
  task automatic push_byte(input logic [7:0] b, input logic eod);
    while (gap_pct > 0 && $urandom_range(99) < gap_pct) begin
      byte_valid <= 1'b0;
      @(negedge clk);
    end
    byte_valid <= 1'b1;
    byte_item  <= '{data_byte: b, end_of_data: eod};
    @(posedge clk);
    while (!byte_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // eod_pos is the index that carries end_of_data, or -1 for none
  task automatic send_bytes(input octet_q_t bytes, input int eod_pos);
    foreach (bytes[i]) push_byte(bytes[i], i == eod_pos);
  endtask

  // stop offering and let every outstanding result come out
  task automatic wait_drained();
    byte_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    // a byte that gives no result may still be inside the block
    repeat (DRAIN_GAP) @(negedge clk);
  endtask

  // apb write: setup phase then access phase
  task automatic write_reg(input logic [0:0] idx, input logic [9:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {22'd0, val};
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == REG_ANALOG_COUNT) cur_ac = val;
    else cur_dc = val;
  endtask

  // one well-formed record with random content for the current counts
  function automatic octet_q_t build_record();
    octet_q_t    rec;
    logic [15:0] w;
    int          nwords;
    repeat (8) rec.push_back(8'($urandom));
    for (int i = 0; i < int'(cur_ac); i++) begin
      // sprinkle missing-sample markers among the analog words
      w = ($urandom_range(9) == 0) ? MISSING_MARK : 16'($urandom);
      rec.push_back(w[7:0]);
      rec.push_back(w[15:8]);
    end
    nwords = (int'(cur_dc) + 15) / 16;
    repeat (nwords) begin
      w = 16'($urandom);
      rec.push_back(w[7:0]);
      rec.push_back(w[15:8]);
    end
    return rec;
  endfunction

  // mostly whole records; some cut short by end of data, some with end of
  // data right on the record boundary; a record too long for what is left
  // of the budget is always cut
  task automatic send_stream(input int budget);
    octet_q_t rec;
    int       sent;
    int       cut;
    int       left;
    int       eod_pos;
    sent = 0;
    while (sent < budget) begin
      rec     = build_record();
      cut     = rec.size();
      left    = budget - sent;
      eod_pos = -1;
      if (cut > left || $urandom_range(99) < 15) begin
        cut     = $urandom_range((cut < left) ? cut : left, 1);
        eod_pos = cut - 1;
      end else if ($urandom_range(9) == 0) begin
        eod_pos = cut - 1;
      end
      rec = rec[0:cut-1];
      send_bytes(rec, eod_pos);
      sent += cut;
    end
  endtask

  initial begin : stimulus
    // per phase: counts, sender gap, receiver stall, byte budget
    static int ph_ac[5]    = '{0, 3, 1, 0, 1023};
    static int ph_dc[5]    = '{0, 5, 16, 1023, 1023};
    static int ph_gap[5]   = '{0, 52, 0, 8, 0};
    static int ph_stall[5] = '{0, 0, 52, 8, 0};
    static int ph_items[5] = '{40, 60, 60, 136, 30};
    octet_q_t  dir;

    repeat (RESET_CYCLES) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: two analog channels, 17 digital channels (second word holds one bit)
    write_reg(REG_ANALOG_COUNT, 10'd2);
    write_reg(REG_DIGITAL_COUNT, 10'd17);
    // all-ones sample number, zero timestamp, missing then most positive analog,
    // then a full first digital word
    dir = '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00,
            8'h00, 8'h80, 8'hFF, 8'h7F, 8'hFF, 8'hFF};
    send_bytes(dir, -1);
    // shrink the digital count mid-record: the pending word now lies past the
    // count and gives only its bit 0; end of data falls on the record boundary
    wait_drained();
    write_reg(REG_DIGITAL_COUNT, 10'd8);
    dir = '{8'h01, 8'h00};
    send_bytes(dir, 1);
    // end of data on the byte that would finish the sample number: field dropped
    dir = '{8'h12, 8'h34, 8'h56, 8'h78};
    send_bytes(dir, 3);

    // random phases: empty sections, small counts, full digital range, both at max
    for (int p = 0; p < 5; p++) begin
      wait_drained();
      write_reg(REG_ANALOG_COUNT, 10'(ph_ac[p]));
      write_reg(REG_DIGITAL_COUNT, 10'(ph_dc[p]));
      gap_pct    = ph_gap[p];
      stall_pct <= ph_stall[p];
      // sixteen bits per digital word here, so a long hold-off backs up the input
      if (p == 2) hold_req <= 1'b1;
      send_stream(ph_items[p]);
    end

    wait_drained();
    if (fail_count == 0 && pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
